### rtl/ptrain_pkg.sv
// Package for the perceptron training step: widths, data types, lane control struct
// and the saturation helper shared by the lanes and the top level.
// Depends on nothing.
package ptrain_pkg;

    localparam int MaxFeatures = 8;
    localparam int NumFeatures = 8;
    localparam int FeatW       = 16;
    localparam int WeightW     = 48;
    localparam int RateW       = 32;
    localparam int RoundShift  = 8;
    localparam int ProdW       = WeightW + FeatW;
    localparam int RateProdW   = RateW + FeatW + 1;
    localparam int StepW       = RateProdW - RoundShift;
    localparam int SumW        = ProdW + 4;

    localparam logic [RateW-1:0] RateReset = RateW'(8590);
    localparam logic signed [RateProdW-1:0] RoundHalf = RateProdW'(1 << (RoundShift - 1));

    typedef logic signed [FeatW-1:0]   feature_t;
    typedef logic signed [WeightW-1:0] weight_t;
    typedef logic signed [WeightW:0]   weight_ext_t;
    typedef logic signed [ProdW-1:0]   prod_t;
    typedef logic signed [StepW-1:0]   step_t;
    typedef logic signed [SumW-1:0]    sum_t;
    typedef logic [RateW-1:0]          rate_t;

    typedef struct packed {
        logic load;
        logic commit;
        logic miss;
        logic target;
    } lane_ctrl_t;

    // Clamps a value one bit wider than a weight to the weight range.
    function automatic weight_t sat_weight(input weight_ext_t v);
        weight_t res;
        if (v[WeightW] != v[WeightW-1])
        begin
            res = v[WeightW] ? {1'b1, {(WeightW-1){1'b0}}} : {1'b0, {(WeightW-1){1'b1}}};
        end
        else
        begin
            res = v[WeightW-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/ptrain_if.sv
// Valid/ready channel interfaces for training samples and training results.
// Depends on ptrain_pkg for the field types.
interface ptrain_sample_if;
    logic                 valid;
    logic                 ready;
    ptrain_pkg::feature_t feature_0;
    ptrain_pkg::feature_t feature_1;
    ptrain_pkg::feature_t feature_2;
    ptrain_pkg::feature_t feature_3;
    ptrain_pkg::feature_t feature_4;
    ptrain_pkg::feature_t feature_5;
    ptrain_pkg::feature_t feature_6;
    ptrain_pkg::feature_t feature_7;
    logic                 target_class;

    modport source (output valid, feature_0, feature_1, feature_2, feature_3, feature_4,
                    feature_5, feature_6, feature_7, target_class, input ready);
    modport sink (input valid, feature_0, feature_1, feature_2, feature_3, feature_4,
                  feature_5, feature_6, feature_7, target_class, output ready);
endinterface

interface ptrain_result_if;
    logic                valid;
    logic                ready;
    logic                prediction;
    logic                mistake;
    ptrain_pkg::weight_t weight_out_0;
    ptrain_pkg::weight_t weight_out_1;
    ptrain_pkg::weight_t weight_out_2;
    ptrain_pkg::weight_t weight_out_3;
    ptrain_pkg::weight_t weight_out_4;
    ptrain_pkg::weight_t weight_out_5;
    ptrain_pkg::weight_t weight_out_6;
    ptrain_pkg::weight_t weight_out_7;
    ptrain_pkg::weight_t bias_out;

    modport source (output valid, prediction, mistake, weight_out_0, weight_out_1,
                    weight_out_2, weight_out_3, weight_out_4, weight_out_5, weight_out_6,
                    weight_out_7, bias_out, input ready);
    modport sink (input valid, prediction, mistake, weight_out_0, weight_out_1,
                  weight_out_2, weight_out_3, weight_out_4, weight_out_5, weight_out_6,
                  weight_out_7, bias_out, output ready);
endinterface

### rtl/ptrain_lane.sv
// One feature lane: holds one weight, forms its product with the feature and the
// rounded update step, and applies the saturating update on a mistake.
// Depends on ptrain_pkg.
module ptrain_lane (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptrain_pkg::feature_t   feature,
    input  ptrain_pkg::rate_t      rate,
    input  ptrain_pkg::lane_ctrl_t ctrl,
    output ptrain_pkg::prod_t      product,
    output ptrain_pkg::weight_t    weight
);

    ptrain_pkg::weight_t weight_reg;
    ptrain_pkg::weight_t weight_next;
    ptrain_pkg::prod_t   prod_reg;
    ptrain_pkg::prod_t   prod_next;
    ptrain_pkg::step_t   step_reg;
    ptrain_pkg::step_t   step_next;

    logic signed [ptrain_pkg::RateProdW-1:0] rate_prod;
    logic signed [ptrain_pkg::RateProdW-1:0] rate_round;
    ptrain_pkg::weight_ext_t                 weight_up;
    ptrain_pkg::weight_ext_t                 weight_down;

    always_comb
    begin
        prod_next  = weight_reg * feature;
        rate_prod  = $signed({1'b0, rate}) * feature;
        rate_round = rate_prod + ptrain_pkg::RoundHalf;
        step_next  = rate_round[ptrain_pkg::RateProdW-1:ptrain_pkg::RoundShift];

        weight_up   = ptrain_pkg::weight_ext_t'(weight_reg) + ptrain_pkg::weight_ext_t'(step_reg);
        weight_down = ptrain_pkg::weight_ext_t'(weight_reg) - ptrain_pkg::weight_ext_t'(step_reg);

        weight_next = weight_reg;
        if (ctrl.commit && ctrl.miss)
        begin
            weight_next = ctrl.target ? ptrain_pkg::sat_weight(weight_up)
                                      : ptrain_pkg::sat_weight(weight_down);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
        end
        else
        begin
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_next;
            step_reg <= step_next;
        end
    end

    assign product = prod_reg;
    assign weight  = weight_reg;

endmodule

### rtl/ptrain_merge.sv
// Merging stage: adds the aligned bias to the lane products and takes the sign
// of the exact sum as the prediction.
// Depends on ptrain_pkg.
module ptrain_merge (
    input  ptrain_pkg::prod_t   products [ptrain_pkg::NumFeatures],
    input  ptrain_pkg::weight_t bias,
    output logic                prediction
);

    ptrain_pkg::sum_t sum;

    always_comb
    begin
        sum = ptrain_pkg::sum_t'($signed({bias, {ptrain_pkg::RoundShift{1'b0}}}));
        for (int i = 0; i < ptrain_pkg::NumFeatures; i++)
        begin
            sum = sum + ptrain_pkg::sum_t'(products[i]);
        end
        prediction = !sum[ptrain_pkg::SumW-1];
    end

endmodule

### rtl/perceptron_train_step.sv
// Perceptron training step: one request carries a sample, one result carries the
// prediction, the mistake flag and the weights and bias after the update.
// The accepted sample is held in stage 1 and commits to the result register when that
// register is empty or read; no new sample is taken until then, as the loop runs from the
// lane products through the merging sum to the weight update that the next sample reads.
// Reset clears weights and bias to zero and loads the default learning rate.
module perceptron_train_step (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  ptrain_pkg::rate_t        cfg_wdata,
    ptrain_sample_if.sink            sample,
    ptrain_result_if.source          result
);

    ptrain_pkg::rate_t      rate_reg;
    ptrain_pkg::rate_t      rate_next;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_target_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   pred_reg;
    logic                   miss_reg;
    ptrain_pkg::weight_t    bias_reg;
    ptrain_pkg::weight_t    bias_next;

    logic                   sample_take;
    logic                   commit;
    logic                   prediction;
    logic                   miss;
    ptrain_pkg::lane_ctrl_t lane_ctrl;
    ptrain_pkg::weight_ext_t bias_up;
    ptrain_pkg::weight_ext_t bias_down;

    ptrain_pkg::feature_t   features [ptrain_pkg::MaxFeatures];
    ptrain_pkg::prod_t      products [ptrain_pkg::NumFeatures];
    ptrain_pkg::weight_t    weights  [ptrain_pkg::MaxFeatures];

    assign features[0] = sample.feature_0;
    assign features[1] = sample.feature_1;
    assign features[2] = sample.feature_2;
    assign features[3] = sample.feature_3;
    assign features[4] = sample.feature_4;
    assign features[5] = sample.feature_5;
    assign features[6] = sample.feature_6;
    assign features[7] = sample.feature_7;

    assign sample.ready = !s1_valid_reg;
    assign sample_take = sample.valid && sample.ready;
    assign commit      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign miss        = prediction != s1_target_reg;

    assign lane_ctrl.load   = sample_take;
    assign lane_ctrl.commit = commit;
    assign lane_ctrl.miss   = miss;
    assign lane_ctrl.target = s1_target_reg;

    for (genvar i = 0; i < ptrain_pkg::MaxFeatures; i++)
    begin : g_lane
        if (i < ptrain_pkg::NumFeatures)
        begin : g_used
            ptrain_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .feature (features[i]),
                .rate    (rate_reg),
                .ctrl    (lane_ctrl),
                .product (products[i]),
                .weight  (weights[i])
            );
        end
        else
        begin : g_unused
            assign weights[i] = '0;
        end
    end

    ptrain_merge u_merge (
        .products   (products),
        .bias       (bias_reg),
        .prediction (prediction)
    );

    always_comb
    begin
        rate_next = cfg_we ? cfg_wdata : rate_reg;

        s1_valid_next = s1_valid_reg;
        if (sample_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (commit)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        bias_up   = ptrain_pkg::weight_ext_t'(bias_reg) + $signed({17'b0, rate_reg});
        bias_down = ptrain_pkg::weight_ext_t'(bias_reg) - $signed({17'b0, rate_reg});
        bias_next = bias_reg;
        if (commit && miss)
        begin
            bias_next = s1_target_reg ? ptrain_pkg::sat_weight(bias_up)
                                      : ptrain_pkg::sat_weight(bias_down);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= ptrain_pkg::RateReset;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bias_reg      <= '0;
        end
        else
        begin
            rate_reg      <= rate_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            bias_reg      <= bias_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            s1_target_reg <= sample.target_class;
        end
        if (commit)
        begin
            pred_reg <= prediction;
            miss_reg <= miss;
        end
    end

    // The weights and bias change only when a new result is loaded, so the
    // state registers themselves serve as the weight fields of the result.
    assign result.valid        = out_valid_reg;
    assign result.prediction   = pred_reg;
    assign result.mistake      = miss_reg;
    assign result.weight_out_0 = weights[0];
    assign result.weight_out_1 = weights[1];
    assign result.weight_out_2 = weights[2];
    assign result.weight_out_3 = weights[3];
    assign result.weight_out_4 = weights[4];
    assign result.weight_out_5 = weights[5];
    assign result.weight_out_6 = weights[6];
    assign result.weight_out_7 = weights[7];
    assign result.bias_out     = bias_reg;

`ifndef SYNTHESIS
    a_one_per_two: assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> !sample.ready)
        else $error("sample accepted in the cycle after another");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(bias_reg) && $stable(weights[0]))
        else $error("state changed while a result was stalled");

    a_no_miss_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !miss) |=> $stable(bias_reg))
        else $error("bias moved without a mistake");

    a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> result.valid && (result.mistake == $past(miss)))
        else $error("committed sample did not reach the result register");
`endif

endmodule

### tb/sv/tb_perceptron_train_step.sv
`timescale 1ns / 1ps
// Self-checking testbench for perceptron_train_step: directed table, then random samples
// over several learning rates, results checked against the table or an in-bench predictor.
// Depends on ptrain_pkg, ptrain_if.sv and the perceptron_train_step RTL.
module tb_perceptron_train_step;

    localparam int                CycleLimit   = 200000;
    localparam int                DrainCycles  = 8;
    localparam int                NumDirected  = 16;
    localparam int                NumPhases    = 7;
    localparam int                PhaseSamples = 205;
    localparam ptrain_pkg::rate_t RateAtReset  = 32'd8590;
    localparam longint            WeightMax    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint            WeightMin    = -WeightMax - 1;

    typedef struct packed {
        logic [ptrain_pkg::MaxFeatures-1:0][ptrain_pkg::FeatW-1:0] feat;
        logic                                                      target;
    } sample_t;

    typedef struct packed {
        logic                                                        prediction;
        logic                                                        mistake;
        logic [ptrain_pkg::MaxFeatures-1:0][ptrain_pkg::WeightW-1:0] weights;
        ptrain_pkg::weight_t                                         bias;
    } train_result_t;

    typedef struct packed {
        sample_t             smp;
        logic                typed;
        logic                pred;
        logic                miss;
        ptrain_pkg::weight_t weight_all;
        ptrain_pkg::weight_t bias;
    } directed_row_t;

    // Rows with typed set carry their result; every weight then has the same value.
    localparam directed_row_t DirectedRows [NumDirected] = '{
        '{'{{8{16'h0000}}, 1'b1}, 1'b1, 1'b1, 1'b0, 48'sd0, 48'sd0},
        '{'{{8{16'h0000}}, 1'b0}, 1'b1, 1'b1, 1'b1, 48'sd0, -48'sd8590},
        '{'{{8{16'h8000}}, 1'b1}, 1'b1, 1'b0, 1'b1, -48'sd1099520, 48'sd0},
        '{'{{8{16'h7FFF}}, 1'b0}, 1'b1, 1'b0, 1'b0, -48'sd1099520, 48'sd0},
        '{'{{8{16'h7FFF}}, 1'b1}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{16'h0040, 16'hFFC0, 16'h0040, 16'hFFC0, 16'h0040, 16'hFFC0, 16'h0040,
            16'hFFC0}, 1'b0}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{16'h0040, 16'hFFC0, 16'h0040, 16'hFFC0, 16'h0040, 16'hFFC0, 16'h0040,
            16'hFFC0}, 1'b1}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{16'h0100, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
            16'h0001}, 1'b1}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{{7{16'h0000}}, 16'h7FFF}, 1'b0}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{16'h8000, {7{16'h0000}}}, 1'b1}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{4{16'h5555, 16'hAAAA}}, 1'b0}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{4{16'hAAAA, 16'h5555}}, 1'b1}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{8{16'hFFFF}}, 1'b0}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{8{16'h0001}}, 1'b1}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{4{16'h8000, 16'h7FFF}}, 1'b0}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0},
        '{'{{8{16'h0040}}, 1'b1}, 1'b0, 1'b0, 1'b0, 48'sd0, 48'sd0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    ptrain_pkg::rate_t cfg_wdata;

    ptrain_pkg::weight_t model_weights [ptrain_pkg::MaxFeatures];
    ptrain_pkg::weight_t model_bias;
    ptrain_pkg::rate_t   model_rate;

    train_result_t expected_q [$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            idle_max;
    int            stall_max;
    int            stall_left = 0;
    logic          result_taken = 1'b0;

    ptrain_sample_if sample_ch();
    ptrain_result_if result_ch();

    perceptron_train_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("** perceptron_train_step: FAILED **");
            $finish;
        end
    end

    function automatic ptrain_pkg::weight_t clamp_weight(input longint v);
        longint c;
        c = (v > WeightMax) ? WeightMax : ((v < WeightMin) ? WeightMin : v);
        return c[ptrain_pkg::WeightW-1:0];
    endfunction

    // Step of bias plus dot product, formed exactly on the current weights.
    function automatic logic class_of(input sample_t s);
        logic signed [79:0]   acc;
        ptrain_pkg::feature_t fv;
        int                   i;
        acc = model_bias;
        acc = acc <<< ptrain_pkg::RoundShift;
        for (i = 0; i < ptrain_pkg::NumFeatures; i++)
        begin
            fv = s.feat[i];
            acc = acc + model_weights[i] * fv;
        end
        return !acc[79];
    endfunction

    function automatic train_result_t train_on(input sample_t s);
        train_result_t        res;
        ptrain_pkg::feature_t fv;
        longint               lr;
        longint               fl;
        longint               step;
        int                   i;
        res.prediction = class_of(s);
        res.mistake = res.prediction != s.target;
        lr = model_rate;
        if (res.mistake)
        begin
            for (i = 0; i < ptrain_pkg::NumFeatures; i++)
            begin
                fv = s.feat[i];
                fl = fv;
                step = (lr * fl + 128) >>> ptrain_pkg::RoundShift;
                model_weights[i] = clamp_weight(s.target ? model_weights[i] + step
                                                         : model_weights[i] - step);
            end
            model_bias = clamp_weight(s.target ? model_bias + lr : model_bias - lr);
        end
        for (i = 0; i < ptrain_pkg::MaxFeatures; i++)
        begin
            res.weights[i] = model_weights[i];
        end
        res.bias = model_bias;
        return res;
    endfunction

    // Entered and left at a falling edge; valid stays high when no gap follows.
    task automatic send_sample(input sample_t s, input train_result_t exp);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.feature_0 = s.feat[0];
        sample_ch.feature_1 = s.feat[1];
        sample_ch.feature_2 = s.feat[2];
        sample_ch.feature_3 = s.feat[3];
        sample_ch.feature_4 = s.feat[4];
        sample_ch.feature_5 = s.feat[5];
        sample_ch.feature_6 = s.feat[6];
        sample_ch.feature_7 = s.feat[7];
        sample_ch.target_class = s.target;
        sample_ch.valid = 1'b1;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        expected_q.push_back(exp);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (result_taken)
        begin
            stall_left = $urandom_range(0, stall_max);
            result_taken = 1'b0;
        end
        if (stall_left > 0)
        begin
            result_ch.ready = 1'b0;
            stall_left--;
        end
        else
        begin
            result_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        train_result_t got;
        train_result_t want;
        int            i;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            result_taken = 1'b1;
            got.prediction = result_ch.prediction;
            got.mistake = result_ch.mistake;
            got.weights[0] = result_ch.weight_out_0;
            got.weights[1] = result_ch.weight_out_1;
            got.weights[2] = result_ch.weight_out_2;
            got.weights[3] = result_ch.weight_out_3;
            got.weights[4] = result_ch.weight_out_4;
            got.weights[5] = result_ch.weight_out_5;
            got.weights[6] = result_ch.weight_out_6;
            got.weights[7] = result_ch.weight_out_7;
            got.bias = result_ch.bias_out;
            if (expected_q.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.prediction !== want.prediction)
                begin
                    $error("prediction: expected %0d, got %0d", want.prediction,
                           got.prediction);
                    mismatch_count++;
                end
                if (got.mistake !== want.mistake)
                begin
                    $error("mistake: expected %0d, got %0d", want.mistake, got.mistake);
                    mismatch_count++;
                end
                for (i = 0; i < ptrain_pkg::MaxFeatures; i++)
                begin
                    if (got.weights[i] !== want.weights[i])
                    begin
                        $error("weight_out_%0d: expected %0d, got %0d", i,
                               $signed(want.weights[i]), $signed(got.weights[i]));
                        mismatch_count++;
                    end
                end
                if (got.bias !== want.bias)
                begin
                    $error("bias_out: expected %0d, got %0d", want.bias, got.bias);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        ptrain_pkg::rate_t phase_rates [NumPhases];
        directed_row_t     row;
        sample_t           smp;
        train_result_t     exp;
        int                phase;
        int                n;
        int                i;
        int                pick;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.feature_0 = '0;
        sample_ch.feature_1 = '0;
        sample_ch.feature_2 = '0;
        sample_ch.feature_3 = '0;
        sample_ch.feature_4 = '0;
        sample_ch.feature_5 = '0;
        sample_ch.feature_6 = '0;
        sample_ch.feature_7 = '0;
        sample_ch.target_class = 1'b0;
        result_ch.ready = 1'b1;
        idle_max = 8;
        stall_max = 8;
        for (i = 0; i < ptrain_pkg::MaxFeatures; i++)
        begin
            model_weights[i] = '0;
        end
        model_bias = '0;
        model_rate = RateAtReset;
        phase_rates = '{32'd0, 32'hFFFF_FFFF, 32'd1, ptrain_pkg::rate_t'($urandom),
                        32'h8000_0000, ptrain_pkg::rate_t'($urandom_range(1, 1 << 20)),
                        RateAtReset};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (n = 0; n < NumDirected; n++)
        begin
            row = DirectedRows[n];
            exp = train_on(row.smp);
            if (row.typed)
            begin
                exp.prediction = row.pred;
                exp.mistake = row.miss;
                for (i = 0; i < ptrain_pkg::MaxFeatures; i++)
                begin
                    exp.weights[i] = (i < ptrain_pkg::NumFeatures) ? row.weight_all : '0;
                end
                exp.bias = row.bias;
            end
            send_sample(row.smp, exp);
        end

        for (phase = 0; phase < NumPhases; phase++)
        begin
            sample_ch.valid = 1'b0;
            while (expected_q.size() != 0)
            begin
                @(negedge clk);
            end
            cfg_we = 1'b1;
            cfg_wdata = phase_rates[phase];
            @(negedge clk);
            cfg_we = 1'b0;
            model_rate = phase_rates[phase];
            idle_max = (phase % 4 == 1 || phase % 4 == 2) ? 0 : 8;
            stall_max = (phase % 4 == 1 || phase % 4 == 3) ? 0 : 8;

            for (n = 0; n < PhaseSamples; n++)
            begin
                for (i = 0; i < ptrain_pkg::MaxFeatures; i++)
                begin
                    pick = $urandom_range(0, 7);
                    case (pick)
                        0: smp.feat[i] = 16'h7FFF;
                        1: smp.feat[i] = 16'h8000;
                        2: smp.feat[i] = 16'h0000;
                        3, 4: smp.feat[i] = 16'($urandom_range(0, 1023) - 512);
                        default: smp.feat[i] = 16'($urandom);
                    endcase
                end
                smp.target = 1'b0;
                pick = $urandom_range(0, 99);
                // Most requests end up misclassified, 45 in 100 by construction, so that the weights keep moving.
                if (pick < 45)
                begin
                    smp.target = !class_of(smp);
                end
                else if (pick < 70)
                begin
                    smp.target = class_of(smp);
                end
                else
                begin
                    smp.target = 1'($urandom);
                end
                exp = train_on(smp);
                send_sample(smp, exp);
            end
        end

        sample_ch.valid = 1'b0;
        while (expected_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);

        if (mismatch_count == 0)
        begin
            $display("** perceptron_train_step: PASSED **");
        end
        else
        begin
            $display("** perceptron_train_step: FAILED **");
        end
        $finish;
    end

endmodule
